[rtl/svna_pkg.sv]
// Shared types and constants of the smooth vertex normal accumulator.
// No dependencies; the square root, divider and top level files import this package.
package svna_pkg;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FACE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // widths of the normalization datapath
    localparam int LEN2_W = 62;   // sum of three squares of 30-bit magnitudes
    localparam int ROOT_W = 31;   // vector length
    localparam int NUM_W  = 45;   // magnitude * 16384 + half length
    localparam int QUOT_W = 15;   // unit component magnitude, at most 16384

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_status;

endpackage

[rtl/svna_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on svna_pkg.
module svna_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [svna_pkg::LEN2_W-1:0] i_value,
    output svna_pkg::t_iter_status      o_status,
    output logic [svna_pkg::ROOT_W-1:0] o_root
);
    import svna_pkg::*;

    localparam int W = LEN2_W + 1;

    logic [W-1:0] r_x;
    logic [W-1:0] r_r;
    logic [W-1:0] r_bit;
    logic [4:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [W-1:0] n_trial;

    assign n_trial = r_r + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle, starting at the top bit pair
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x   <= {1'b0, i_value};
            r_r   <= '0;
            r_bit <= {1'b1, {(W-1){1'b0}}};
        end else if (r_busy) begin
            if (r_x >= n_trial) begin
                r_x <= r_x - n_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_root        = r_r[ROOT_W-1:0];

endmodule

[rtl/svna_div.sv]
// Restoring divider, one quotient bit per cycle, for unit components.
// Depends on svna_pkg.
module svna_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [svna_pkg::NUM_W-1:0]  i_num,
    input  logic [svna_pkg::ROOT_W-1:0] i_den,
    output svna_pkg::t_iter_status      o_status,
    output logic [svna_pkg::QUOT_W-1:0] o_quot
);
    import svna_pkg::*;

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // compare and subtract the shifted divisor, top quotient bit first
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= i_num;
            r_den  <= {i_den, {(QUOT_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_den) begin
                r_rem  <= r_rem - r_den;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

[rtl/smooth_vertex_normal_accumulator.sv]
// Top level: sequencer, position and normal-sum tables, shared multiplier.
// Depends on svna_pkg, svna_sqrt and svna_div.
//
// Items are taken while busy is low. A clear, and reset itself, run a
// clearing pass over all VERTEX_COUNT entries of the sum table with busy
// high. During an add face or a read, one shared multiplier serves the
// six cross products and three squares, the vector is scaled one bit per
// cycle (up to 29 steps), the square root runs 32 steps and each of three
// divisions 15 steps, and an add face ends with a read-modify-write of
// each vertex sum. A zero vector skips the root and the divisions. A read
// result appears on the outputs with strobe high for one cycle; the
// receiver cannot stall it, so it must take it then.
module smooth_vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [11:0]        i_index_a,
    input  logic [11:0]        i_index_b,
    input  logic [11:0]        i_index_c,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic signed [15:0] i_coord_z,
    output logic               strobe,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic               o_zero_length
);
    import svna_pkg::*;

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_ADD   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    function automatic logic [AW-1:0] to_addr(input logic [11:0] idx);
        logic [27:0] e;
        e = {16'b0, idx};
        return e[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [11:0] idx);
        return {16'b0, idx} < 28'(VERTEX_COUNT);
    endfunction

    function automatic logic [35:0] to_mag(input logic [35:0] v);
        return v[35] ? (~v + 36'd1) : v;
    endfunction

    function automatic logic [23:0] sat_add(input logic [23:0] s, input logic [15:0] n);
        logic [24:0] t;
        t = {s[23], s} + {{9{n[15]}}, n};
        if (t[24] != t[23]) begin
            return t[24] ? 24'h800000 : 24'h7FFFFF;
        end
        return t[23:0];
    endfunction

    // tables
    logic [47:0] pos_mem [VERTEX_COUNT];
    logic [72:0] sum_mem [VERTEX_COUNT];
    logic [47:0] r_pos_rd;
    logic [72:0] r_sum_rd;

    logic [3:0]         r_state;
    logic [2:0]         r_cnt;
    logic [1:0]         r_k;
    logic               r_is_read;
    logic               r_zero;
    logic [AW-1:0]      r_sweep;
    logic [AW-1:0]      r_idx [3];
    logic signed [15:0] r_v0 [3];
    logic signed [16:0] r_d10 [3];
    logic signed [16:0] r_d20 [3];
    logic [34:0]        r_acc;
    logic [35:0]        r_mag [3];
    logic               r_neg [3];
    logic [LEN2_W-1:0]  r_len2;
    logic [ROOT_W-1:0]  r_len;
    logic [15:0]        r_n [3];
    logic signed [61:0] r_prod;

    logic               accept;
    logic               pos_we;
    logic [AW-1:0]      pos_raddr;
    logic [AW-1:0]      sum_raddr;
    logic               sum_we;
    logic [AW-1:0]      sum_waddr;
    logic [72:0]        sum_wdata;
    logic signed [30:0] mul_a;
    logic signed [30:0] mul_b;
    logic [35:0]        cross_diff;
    logic [35:0]        mag_max;
    logic [35:0]        mag_01;
    logic [AW-1:0]      idx_k;
    logic [35:0]        mag_k;
    logic               neg_k;
    logic [72:0]        sum_cur;
    logic               sqrt_start;
    logic               div_start;
    t_iter_status       sqrt_st;
    t_iter_status       div_st;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [QUOT_W-1:0]  div_quot;
    logic [NUM_W-1:0]   div_num;
    logic [15:0]        n_unit;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pos_we = accept && (i_operation == OP_LOAD) && in_range(i_index_a);

    // select the current vertex and component
    always_comb begin
        case (r_k)
            2'd1:    begin idx_k = r_idx[1]; mag_k = r_mag[1]; neg_k = r_neg[1]; end
            2'd2:    begin idx_k = r_idx[2]; mag_k = r_mag[2]; neg_k = r_neg[2]; end
            default: begin idx_k = r_idx[0]; mag_k = r_mag[0]; neg_k = r_neg[0]; end
        endcase
    end

    // table addresses
    always_comb begin
        case (r_cnt)
            3'd1:    pos_raddr = r_idx[1];
            3'd2:    pos_raddr = r_idx[2];
            default: pos_raddr = r_idx[0];
        endcase
        sum_raddr = (r_state == S_ADD) ? idx_k : r_idx[0];
        sum_cur   = r_sum_rd[72] ? r_sum_rd : 73'd0;
        if (r_state == S_SWEEP) begin
            sum_we    = 1'b1;
            sum_waddr = r_sweep;
            sum_wdata = '0;
        end else begin
            sum_we    = (r_state == S_ADD) && (r_cnt == 3'd1);
            sum_waddr = idx_k;
            sum_wdata = {1'b1, sat_add(sum_cur[71:48], r_n[0]),
                         sat_add(sum_cur[47:24], r_n[1]), sat_add(sum_cur[23:0], r_n[2])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[to_addr(i_index_a)] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        r_pos_rd <= pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_rd <= sum_mem[sum_raddr];
    end

    // shared multiplier operands: cross terms, then squares
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_CROSS) begin
            case (r_cnt)
                3'd0:    begin mul_a = 31'(r_d20[1]); mul_b = 31'(r_d10[2]); end
                3'd1:    begin mul_a = 31'(r_d20[2]); mul_b = 31'(r_d10[1]); end
                3'd2:    begin mul_a = 31'(r_d20[2]); mul_b = 31'(r_d10[0]); end
                3'd3:    begin mul_a = 31'(r_d20[0]); mul_b = 31'(r_d10[2]); end
                3'd4:    begin mul_a = 31'(r_d20[0]); mul_b = 31'(r_d10[1]); end
                3'd5:    begin mul_a = 31'(r_d20[1]); mul_b = 31'(r_d10[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_SQ) begin
            case (r_cnt)
                3'd0:    begin mul_a = {1'b0, r_mag[0][29:0]}; mul_b = {1'b0, r_mag[0][29:0]}; end
                3'd1:    begin mul_a = {1'b0, r_mag[1][29:0]}; mul_b = {1'b0, r_mag[1][29:0]}; end
                3'd2:    begin mul_a = {1'b0, r_mag[2][29:0]}; mul_b = {1'b0, r_mag[2][29:0]}; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign cross_diff = {r_acc[34], r_acc} - r_prod[35:0];
    assign mag_01     = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign mag_max    = (mag_01 > r_mag[2]) ? mag_01 : r_mag[2];
    assign div_num    = {1'b0, mag_k[29:0], 14'b0} + NUM_W'(r_len >> 1);
    assign n_unit     = neg_k ? (16'd0 - {1'b0, div_quot}) : {1'b0, div_quot};
    assign sqrt_start = (r_state == S_SQRT) && (r_cnt == 3'd0) && !sqrt_st.busy;
    assign div_start  = (r_state == S_DIV) && (r_cnt == 3'd0) && !div_st.busy;

    svna_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sqrt_start),
        .i_value  (r_len2),
        .o_status (sqrt_st),
        .o_root   (sqrt_root)
    );

    svna_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (r_len),
        .o_status (div_st),
        .o_quot   (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            strobe  <= 1'b0;
        end else begin
            strobe <= 1'b0;
            case (r_state)
                S_SWEEP: begin
                    if (r_sweep == AW'(VERTEX_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (accept) begin
                        r_idx[0] <= to_addr(i_index_a);
                        r_idx[1] <= to_addr(i_index_b);
                        r_idx[2] <= to_addr(i_index_c);
                        case (i_operation)
                            OP_FACE: begin
                                r_is_read <= 1'b0;
                                if (in_range(i_index_a) && in_range(i_index_b) &&
                                    in_range(i_index_c)) begin
                                    r_state <= S_POS;
                                end
                            end
                            OP_READ: begin
                                r_is_read <= 1'b1;
                                if (in_range(i_index_a)) begin
                                    r_state <= S_SUM;
                                end else begin
                                    r_n[0]  <= '0;
                                    r_n[1]  <= '0;
                                    r_n[2]  <= '0;
                                    r_zero  <= 1'b1;
                                    r_state <= S_OUT;
                                end
                            end
                            OP_CLEAR: begin
                                r_sweep <= '0;
                                r_state <= S_SWEEP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // fetch the three positions and form the edge vectors
                S_POS: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        r_v0[0] <= r_pos_rd[47:32];
                        r_v0[1] <= r_pos_rd[31:16];
                        r_v0[2] <= r_pos_rd[15:0];
                    end else if (r_cnt == 3'd2) begin
                        r_d10[0] <= {r_pos_rd[47], r_pos_rd[47:32]} - {r_v0[0][15], r_v0[0]};
                        r_d10[1] <= {r_pos_rd[31], r_pos_rd[31:16]} - {r_v0[1][15], r_v0[1]};
                        r_d10[2] <= {r_pos_rd[15], r_pos_rd[15:0]}  - {r_v0[2][15], r_v0[2]};
                    end else if (r_cnt == 3'd3) begin
                        r_d20[0] <= {r_pos_rd[47], r_pos_rd[47:32]} - {r_v0[0][15], r_v0[0]};
                        r_d20[1] <= {r_pos_rd[31], r_pos_rd[31:16]} - {r_v0[1][15], r_v0[1]};
                        r_d20[2] <= {r_pos_rd[15], r_pos_rd[15:0]}  - {r_v0[2][15], r_v0[2]};
                        r_cnt    <= '0;
                        r_state  <= S_CROSS;
                    end
                end
                // accumulate cross product terms from the multiplier
                S_CROSS: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1 || r_cnt == 3'd3 || r_cnt == 3'd5) begin
                        r_acc <= r_prod[34:0];
                    end
                    if (r_cnt == 3'd2) begin
                        r_mag[0] <= to_mag(cross_diff);
                        r_neg[0] <= cross_diff[35];
                    end
                    if (r_cnt == 3'd4) begin
                        r_mag[1] <= to_mag(cross_diff);
                        r_neg[1] <= cross_diff[35];
                    end
                    if (r_cnt == 3'd6) begin
                        r_mag[2] <= to_mag(cross_diff);
                        r_neg[2] <= cross_diff[35];
                        r_state  <= S_NORM;
                    end
                end
                // fetch the vertex sum for a read
                S_SUM: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        r_mag[0] <= to_mag({{12{sum_cur[71]}}, sum_cur[71:48]});
                        r_mag[1] <= to_mag({{12{sum_cur[47]}}, sum_cur[47:24]});
                        r_mag[2] <= to_mag({{12{sum_cur[23]}}, sum_cur[23:0]});
                        r_neg[0] <= sum_cur[71];
                        r_neg[1] <= sum_cur[47];
                        r_neg[2] <= sum_cur[23];
                        r_state  <= S_NORM;
                    end
                end
                // scale magnitudes one bit per cycle into [2^29, 2^30)
                S_NORM: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (mag_max == 36'd0) begin
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= '0;
                        r_zero  <= 1'b1;
                        r_state <= r_is_read ? S_OUT : S_ADD;
                    end else if (mag_max[35:30] != 6'd0) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else if (!mag_max[29]) begin
                        r_mag[0] <= r_mag[0] << 1;
                        r_mag[1] <= r_mag[1] << 1;
                        r_mag[2] <= r_mag[2] << 1;
                    end else begin
                        r_len2  <= '0;
                        r_state <= S_SQ;
                    end
                end
                // sum of squares
                S_SQ: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_len2 <= r_len2 + r_prod[LEN2_W-1:0];
                    end
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_start) begin
                        r_cnt <= 3'd1;
                    end
                    if (sqrt_st.done) begin
                        r_len   <= sqrt_root;
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                // one division per component
                S_DIV: begin
                    if (div_start) begin
                        r_cnt <= 3'd1;
                    end
                    if (div_st.done) begin
                        r_cnt <= '0;
                        case (r_k)
                            2'd0:    r_n[0] <= n_unit;
                            2'd1:    r_n[1] <= n_unit;
                            default: r_n[2] <= n_unit;
                        endcase
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_zero  <= 1'b0;
                            r_state <= r_is_read ? S_OUT : S_ADD;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                // read-modify-write each vertex sum
                S_ADD: begin
                    if (r_cnt == 3'd0) begin
                        r_cnt <= 3'd1;
                    end else begin
                        r_cnt <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    strobe  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_normal_x    <= r_n[0];
            o_normal_y    <= r_n[1];
            o_normal_z    <= r_n[2];
            o_zero_length <= r_zero;
        end
    end

endmodule

[rtl/svna_checker.sv]
// Port-level checks of the smooth vertex normal accumulator, bound to it.
// Depends on the top level's port list only.
module svna_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input logic signed [15:0] o_normal_x,
    input logic signed [15:0] o_normal_y,
    input logic signed [15:0] o_normal_z,
    input logic               o_zero_length
);

    // reset starts a clearing pass and kills any result
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy && !strobe)
        else $error("reset did not start clearing pass");

    // a zero-length result carries zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && o_zero_length |-> o_normal_x == 16'sd0 && o_normal_y == 16'sd0 &&
        o_normal_z == 16'sd0)
        else $error("zero-length result has nonzero fields");

    // a unit result is nonzero
    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe && !o_zero_length |->
        o_normal_x != 16'sd0 || o_normal_y != 16'sd0 || o_normal_z != 16'sd0)
        else $error("unit result is zero");

    // components stay within unit range
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 &&
        o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384 &&
        o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)
        else $error("result component out of range");

endmodule

bind smooth_vertex_normal_accumulator svna_checker u_svna_checker (.*);
